### sv/jfrtw_pkg.sv
// ----------------------------------------------------------------------------
// jfrtw_pkg: shared types and constants of the job frame receiver
// Holds the function codes, the frame constants, the controller state type
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package jfrtw_pkg;

   // Function codes carried in the input item's tuser field.
   typedef enum logic [1:0] {
      FUNC_BYTE = 2'd0,
      FUNC_TICK = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   // Frame layout constants.
   localparam logic [7:0]  HEADER_BYTE   = 8'hFB;
   localparam int          PAYLOAD_BYTES = 12;
   localparam logic [3:0]  LAST_INDEX    = 4'(PAYLOAD_BYTES - 1);
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;
   localparam logic [15:0] TIMEOUT_MAX   = 16'hFFFF;
   localparam logic [7:0]  NIBBLE_MASK   = 8'hF0;
   localparam logic [7:0]  ZERO_RAMP_LOW = 8'h01;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TBL_RD,
      ST_TBL_CAP,
      ST_RUN_RD,
      ST_RUN_WR,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic tbl_rd;
      logic tbl_cap;
      logic run_rd;
      logic run_wr;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_ok;
      logic read_hit;
      logic run_last;
      logic out_free;
   } status_type;

endpackage

### sv/job_frame_receiver_table_writer.sv
// ----------------------------------------------------------------------------
// job_frame_receiver_table_writer: job frame receiver and slat job table
// Receives framed job commands byte by byte, times out partial frames on
// ticks, writes 8-byte job records into a slat table and serves byte reads.
// ----------------------------------------------------------------------------
// Each input item is a received byte, a time tick or a table read, and
// produces exactly one result item. A byte, a tick, an unused function code
// or a read of a row above the slat count goes from acceptance straight to
// the final state, where its result is moved into the output register. A
// read of a valid row passes through the table read and capture states
// first. The byte that completes a frame with a valid start slat first runs
// a read state and a write state for each record of the run (up to 255
// records), since each record is a read-modify-write on the single read
// and single write port of the job table memory. The next item is accepted
// in the cycle after the result has been moved into the output register;
// while that register still holds an untaken result, the block waits in
// its final state until the consumer takes it. The table reads as zero
// after reset through per-row valid flags, so there is no clearing pass.
module job_frame_receiver_table_writer
   import jfrtw_pkg::*;
#(
   parameter int SLAT_COUNT = 72
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rx_byte[7:0], read_slat[14:8], read_field[17:15]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // read_data[7:0]
   output logic [2:0]  rsp_tuser,   // frame_applied[0], start_rejected[1], frame_dropped[2]
   // Timeout register write.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencing.
   jfrtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   jfrtw_dpath #(
      .SLAT_COUNT (SLAT_COUNT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### sv/jfrtw_ram.sv
// ----------------------------------------------------------------------------
// jfrtw_ram: generic single-write, single-read memory
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module jfrtw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 73
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/jfrtw_ctrl.sv
// ----------------------------------------------------------------------------
// jfrtw_ctrl: controller of the job frame receiver
// Sequences item acceptance, table reads, the record write run of a
// completed frame and the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module jfrtw_ctrl
   import jfrtw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               priority if (status.frame_ok) begin
                  state_in = ST_RUN_RD;
               end else if (status.read_hit) begin
                  state_in = ST_TBL_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_TBL_RD:  state_in = ST_TBL_CAP;
         ST_TBL_CAP: state_in = ST_DONE;
         ST_RUN_RD:  state_in = ST_RUN_WR;
         ST_RUN_WR: begin
            state_in = status.run_last ? ST_DONE : ST_RUN_RD;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_TBL_RD:  cmd.tbl_rd  = 1'b1;
         ST_TBL_CAP: cmd.tbl_cap = 1'b1;
         ST_RUN_RD:  cmd.run_rd  = 1'b1;
         ST_RUN_WR:  cmd.run_wr  = 1'b1;
         ST_DONE:    cmd.out_load = status.out_free;
         default: ;
      endcase
   end

endmodule

### sv/jfrtw_dpath.sv
// ----------------------------------------------------------------------------
// jfrtw_dpath: datapath of the job frame receiver
// Holds the receive state, the payload bytes, the timeout counter, the job
// table with its row valid flags, the run counters and the output register.
// ----------------------------------------------------------------------------
module jfrtw_dpath
   import jfrtw_pkg::*;
#(
   parameter int SLAT_COUNT = 72
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic [2:0]  rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  cmd_type     cmd,
   output status_type  status
);

   localparam int DEPTH = SLAT_COUNT + 1;
   localparam int ROW_W = $clog2(DEPTH);
   localparam int VW    = $clog2(SLAT_COUNT + 256);
   localparam logic [VW-1:0]    N_V   = VW'(SLAT_COUNT);
   localparam logic [ROW_W-1:0] N_M1  = ROW_W'(SLAT_COUNT - 1);

   // Input fields.
   func_type   func;
   logic [7:0] rx_byte;
   logic [6:0] read_slat;
   logic [2:0] read_field;

   assign func       = func_type'(req_tuser);
   assign rx_byte    = req_tdata[7:0];
   assign read_slat  = req_tdata[14:8];
   assign read_field = req_tdata[17:15];

   // Registers and their next values.
   logic [15:0]      ticks_ff, ticks_in;
   logic             rx_phase_ff, rx_phase_in;
   logic [3:0]       payload_count_ff, payload_count_in;
   logic [15:0]      timeout_ff, timeout_in;
   logic [7:0]       store_ff [PAYLOAD_BYTES];
   logic             store_we;
   logic             applied_ff, applied_in;
   logic             rejected_ff, rejected_in;
   logic             dropped_ff, dropped_in;
   logic [7:0]       res_data_ff, res_data_in;
   logic [6:0]       rd_slat_ff, rd_slat_in;
   logic [2:0]       rd_field_ff, rd_field_in;
   logic [VW-1:0]    v_ff, v_in;
   logic [ROW_W-1:0] m_ff, m_in;
   logic [7:0]       runs_ff, runs_in;
   logic [DEPTH-1:0] valid_ff;
   logic             valid_q_ff;
   logic             rsp_tvalid_ff;
   logic [7:0]       rsp_tdata_ff;
   logic [2:0]       rsp_tuser_ff;

   // Frame decoding.
   logic [VW-1:0]    start_v;
   logic             start_ok;
   logic             frame_end;
   logic [15:0]      tick_next;
   logic [ROW_W-1:0] row;
   logic [ROW_W-1:0] rd_addr;
   logic             rd_en;
   logic [63:0]      ram_rdata;
   logic [63:0]      old_rec;
   logic [63:0]      new_rec;
   logic [15:0]      ramp_a;
   logic [15:0]      ramp_b;

   assign start_v   = VW'(store_ff[0]);
   assign start_ok  = (start_v != '0) && (start_v <= N_V);
   assign frame_end = (func == FUNC_BYTE) && rx_phase_ff && (payload_count_ff == LAST_INDEX);
   assign tick_next = (timeout_ff < TIMEOUT_MAX) ? timeout_ff + 16'd1 : timeout_ff;

   // Status to the controller.
   assign status.frame_ok = frame_end && start_ok;
   assign status.read_hit = (func == FUNC_READ) && (VW'(read_slat) <= N_V);
   assign status.run_last = (runs_ff == 8'd1);
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;

   // The row of the run: the running slat, taken modulo the slat count
   // once it has passed the last slat.
   assign row = (v_ff > N_V) ? m_ff : v_ff[ROW_W-1:0];

   // Receive state, result flags and run counters.
   always_comb begin
      ticks_in         = csr_wr_en ? csr_wr_data : ticks_ff;
      rx_phase_in      = rx_phase_ff;
      payload_count_in = payload_count_ff;
      timeout_in       = timeout_ff;
      store_we         = 1'b0;
      applied_in       = applied_ff;
      rejected_in      = rejected_ff;
      dropped_in       = dropped_ff;
      res_data_in      = res_data_ff;
      rd_slat_in       = rd_slat_ff;
      rd_field_in      = rd_field_ff;
      v_in             = v_ff;
      m_in             = m_ff;
      runs_in          = runs_ff;
      if (cmd.accept) begin
         applied_in  = 1'b0;
         rejected_in = 1'b0;
         dropped_in  = 1'b0;
         res_data_in = 8'd0;
         rd_slat_in  = read_slat;
         rd_field_in = read_field;
         unique case (func)
            FUNC_BYTE: begin
               if (!rx_phase_ff) begin
                  if (rx_byte == HEADER_BYTE) begin
                     rx_phase_in      = 1'b1;
                     payload_count_in = 4'd0;
                     timeout_in       = 16'd0;
                  end
               end else begin
                  store_we = 1'b1;
                  if (frame_end) begin
                     applied_in       = start_ok;
                     rejected_in      = !start_ok;
                     rx_phase_in      = 1'b0;
                     payload_count_in = 4'd0;
                     timeout_in       = 16'd0;
                     v_in             = start_v;
                     m_in             = (start_v == N_V) ? '0 : ROW_W'(store_ff[0]);
                     runs_in          = (store_ff[1] < 8'd2) ? 8'd1 : store_ff[1];
                  end else begin
                     payload_count_in = payload_count_ff + 4'd1;
                  end
               end
            end
            FUNC_TICK: begin
               if (rx_phase_ff) begin
                  if (tick_next >= ticks_ff) begin
                     dropped_in       = 1'b1;
                     rx_phase_in      = 1'b0;
                     payload_count_in = 4'd0;
                     timeout_in       = 16'd0;
                  end else begin
                     timeout_in = tick_next;
                  end
               end
            end
            default: ;
         endcase
      end
      // Capture of the table byte of a read.
      if (cmd.tbl_cap) begin
         res_data_in = valid_q_ff ? ram_rdata[{rd_field_ff, 3'b000} +: 8] : 8'd0;
      end
      // Advance to the next slat of the run.
      if (cmd.run_wr) begin
         v_in    = v_ff + VW'(1);
         m_in    = (m_ff == N_M1) ? '0 : m_ff + ROW_W'(1);
         runs_in = runs_ff - 8'd1;
      end
   end

   // Record builder: a clear request on an occupied row only zeroes the
   // job byte, otherwise the whole record is rewritten.
   assign old_rec = valid_q_ff ? ram_rdata : 64'd0;
   assign ramp_a  = {store_ff[6], store_ff[7]};
   assign ramp_b  = {store_ff[10], store_ff[11]};

   always_comb begin
      new_rec = old_rec;
      if ((store_ff[2] == 8'd0) && (old_rec[7:0] != 8'd0)) begin
         new_rec[7:0] = 8'd0;
      end else begin
         new_rec[7:0]   = store_ff[2];
         new_rec[15:8]  = store_ff[4];
         new_rec[23:16] = (store_ff[5] & NIBBLE_MASK)
                          | ((ramp_a == 16'd0) ? 8'd0 : {4'd0, ramp_a[15:12]});
         new_rec[31:24] = (ramp_a == 16'd0) ? ZERO_RAMP_LOW : ramp_a[11:4];
         new_rec[39:32] = store_ff[8];
         new_rec[47:40] = (store_ff[9] & NIBBLE_MASK)
                          | ((ramp_b == 16'd0) ? 8'd0 : {4'd0, ramp_b[15:12]});
         new_rec[55:48] = (ramp_b == 16'd0) ? ZERO_RAMP_LOW : ramp_b[11:4];
         new_rec[63:56] = store_ff[3];
      end
   end

   // Job table memory.
   assign rd_en   = cmd.tbl_rd || cmd.run_rd;
   assign rd_addr = cmd.tbl_rd ? ROW_W'(rd_slat_ff) : row;

   jfrtw_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.run_wr),
      .wr_addr (row),
      .wr_data (new_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Control registers, row valid flags and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff         <= TIMEOUT_RESET;
         rx_phase_ff      <= 1'b0;
         payload_count_ff <= 4'd0;
         timeout_ff       <= 16'd0;
         valid_ff         <= '0;
         valid_q_ff       <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         ticks_ff         <= ticks_in;
         rx_phase_ff      <= rx_phase_in;
         payload_count_ff <= payload_count_in;
         timeout_ff       <= timeout_in;
         if (rd_en) begin
            valid_q_ff <= valid_ff[rd_addr];
         end
         if (cmd.run_wr) begin
            valid_ff[row] <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[payload_count_ff] <= rx_byte;
      end
      applied_ff  <= applied_in;
      rejected_ff <= rejected_in;
      dropped_ff  <= dropped_in;
      res_data_ff <= res_data_in;
      rd_slat_ff  <= rd_slat_in;
      rd_field_ff <= rd_field_in;
      v_ff        <= v_in;
      m_ff        <= m_in;
      runs_ff     <= runs_in;
      if (cmd.out_load) begin
         rsp_tdata_ff <= res_data_ff;
         rsp_tuser_ff <= {dropped_ff, rejected_ff, applied_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A new result is loaded only into an empty or draining output register.
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   // Every record write follows the read of the same row.
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.run_wr |-> $past(cmd.run_rd))
      else $error("record write without a preceding read");

   // The payload count never reaches the frame length.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      payload_count_ff <= LAST_INDEX)
      else $error("payload count out of range");

   // While hunting the payload count rests at zero.
   a_hunt_count: assert property (@(posedge clock) disable iff (reset)
      !rx_phase_ff |-> (payload_count_ff == 4'd0))
      else $error("payload count nonzero while hunting");

   // A result carries at most one of its event flags.
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> $onehot0(rsp_tuser_ff))
      else $error("more than one event flag in a result");

endmodule

### verif/job_frame_checker.sv
// ----------------------------------------------------------------------------
// job_frame_checker: response predictor and comparator for the frame receiver
// Watches the input, result and register channels of the job frame receiver.
// It keeps its own copy of the receive state and the slat job table, works
// out the result of every accepted item and compares each accepted result,
// field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module job_frame_checker
   import jfrtw_pkg::*;
#(
   parameter int SLAT_COUNT = 72
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // rx_byte[7:0], read_slat[14:8], read_field[17:15]
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // read_data[7:0]
   input  logic [2:0]  rsp_tuser,   // frame_applied[0], start_rejected[1], frame_dropped[2]
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatch_count,
   output int          responses_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] read_data;
      logic       frame_dropped;
      logic       start_rejected;
      logic       frame_applied;
   } response_type;

   // Shadow copy of the block's register and state.
   logic [15:0]  timeout_ticks;
   logic         collecting;
   logic [3:0]   byte_count;
   logic [7:0]   payload [0:PAYLOAD_BYTES-1];
   logic [15:0]  tick_count;
   logic [7:0]   slat_records [0:SLAT_COUNT][0:7];
   response_type response_queue [$];

   // Rewrite one slat record from the collected payload, or clear its job.
   task automatic write_job_record(input int row);
      logic [15:0] ramp_a;
      logic [15:0] ramp_b;
      ramp_a = {payload[6], payload[7]};
      ramp_b = {payload[10], payload[11]};
      if (payload[2] == 8'd0 && slat_records[row][0] != 8'd0) begin
         slat_records[row][0] = 8'd0;
      end else begin
         slat_records[row][0] = payload[2];
         slat_records[row][7] = payload[3];
         slat_records[row][1] = payload[4];
         slat_records[row][2] = payload[5] & NIBBLE_MASK;
         slat_records[row][4] = payload[8];
         slat_records[row][5] = payload[9] & NIBBLE_MASK;
         // A zero ramp stores one in its low byte and leaves the nibble alone.
         if (ramp_a == 16'd0) begin
            slat_records[row][3] = ZERO_RAMP_LOW;
         end else begin
            slat_records[row][3] = ramp_a[11:4];
            slat_records[row][2] = slat_records[row][2] | {4'd0, ramp_a[15:12]};
         end
         if (ramp_b == 16'd0) begin
            slat_records[row][6] = ZERO_RAMP_LOW;
         end else begin
            slat_records[row][6] = ramp_b[11:4];
            slat_records[row][5] = slat_records[row][5] | {4'd0, ramp_b[15:12]};
         end
      end
   endtask

   // Apply a complete frame to its run of slats; rows past the end wrap round.
   task automatic apply_frame(output logic applied);
      int start_slat;
      int run_length;
      int row;
      start_slat = payload[0];
      run_length = (payload[1] < 8'd2) ? 1 : int'(payload[1]);
      applied = (start_slat >= 1 && start_slat <= SLAT_COUNT);
      if (applied) begin
         for (int k = 0; k < run_length; k++) begin
            row = start_slat + k;
            if (row > SLAT_COUNT) begin
               row = row % SLAT_COUNT;
            end
            write_job_record(row);
         end
      end
   endtask

   // Advance the shadow state by one item and work out its result.
   task automatic compute_response(input func_type fn, input logic [7:0] rx_byte,
                                   input logic [6:0] read_slat, input logic [2:0] read_field,
                                   output response_type resp);
      logic ok;
      resp = '0;
      case (fn)
         FUNC_BYTE: begin
            if (!collecting) begin
               if (rx_byte == HEADER_BYTE) begin
                  collecting = 1'b1;
                  byte_count = 4'd0;
                  tick_count = 16'd0;
               end
            end else begin
               // A header byte seen here is simply more payload.
               payload[byte_count] = rx_byte;
               byte_count = byte_count + 4'd1;
               if (byte_count >= PAYLOAD_BYTES) begin
                  apply_frame(ok);
                  resp.frame_applied  = ok;
                  resp.start_rejected = !ok;
                  collecting = 1'b0;
                  byte_count = 4'd0;
                  tick_count = 16'd0;
               end
            end
         end
         FUNC_TICK: begin
            if (collecting) begin
               if (tick_count < TIMEOUT_MAX) begin
                  tick_count = tick_count + 16'd1;
               end
               if (tick_count >= timeout_ticks) begin
                  resp.frame_dropped = 1'b1;
                  collecting = 1'b0;
                  byte_count = 4'd0;
                  tick_count = 16'd0;
               end
            end
         end
         FUNC_READ: begin
            if (read_slat <= SLAT_COUNT) begin
               resp.read_data = slat_records[read_slat][read_field];
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic int field_mismatch(input string name, input int exp_value,
                                         input int act_value);
      if (exp_value != act_value) begin
         $error("%s: expected %0h, got %0h", name, exp_value, act_value);
         return 1;
      end
      return 0;
   endfunction

   // Register writes, result comparison and prediction, all at the rising edge.
   always @(posedge clock) begin : scoreboard
      response_type expected;
      response_type predicted;
      if (reset) begin
         timeout_ticks = TIMEOUT_RESET;
         collecting = 1'b0;
         byte_count = 4'd0;
         tick_count = 16'd0;
         for (int r = 0; r <= SLAT_COUNT; r++) begin
            for (int f = 0; f < 8; f++) begin
               slat_records[r][f] = 8'd0;
            end
         end
         response_queue.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            timeout_ticks = csr_wr_data;
         end
         // A result leaving now belongs to an item accepted at an earlier edge.
         if (rsp_tvalid && rsp_tready) begin
            if (response_queue.size() == 0) begin
               $error("result item with none outstanding: tdata %0h, tuser %0h",
                      rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               expected = response_queue.pop_front();
               mismatch_count += field_mismatch("read_data", expected.read_data, rsp_tdata);
               mismatch_count += field_mismatch("frame_applied", expected.frame_applied,
                                                rsp_tuser[0]);
               mismatch_count += field_mismatch("start_rejected", expected.start_rejected,
                                                rsp_tuser[1]);
               mismatch_count += field_mismatch("frame_dropped", expected.frame_dropped,
                                                rsp_tuser[2]);
            end
         end
         if (req_tvalid && req_tready) begin
            compute_response(func_type'(req_tuser), req_tdata[7:0], req_tdata[14:8],
                             req_tdata[17:15], predicted);
            response_queue.push_back(predicted);
         end
      end
      responses_due = response_queue.size();
   end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the job frame receiver and table writer
// Drives well-formed job frames, broken frames, ticks, table reads and noise
// under several timeout settings, with random pacing on both channels. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb
   import jfrtw_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLAT_COUNT    = 72;
   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS   = 255;
   localparam int CYCLE_LIMIT   = 4_000_000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [23:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;

   int          mismatch_count;
   int          responses_due;
   int          cycle_count = 0;
   int          items_sent  = 0;
   bit          quiet       = 1'b0;
   logic [15:0] timeout_now = TIMEOUT_RESET;
   logic [15:0] phase_timeouts [0:5] = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd200, 16'd30};

   job_frame_receiver_table_writer #(
      .SLAT_COUNT(SLAT_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   job_frame_checker #(
      .SLAT_COUNT(SLAT_COUNT)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count),
      .responses_due(responses_due)
   );

   always #CLOCK_HALF clock = ~clock;

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one, none while quiet.
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) begin
         return 0;
      end
      if (roll < 94) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [6:0] random_slat();
      if ($urandom_range(0, 99) < 85) begin
         return 7'($urandom_range(0, SLAT_COUNT));
      end
      return 7'($urandom_range(SLAT_COUNT + 1, 127));
   endfunction

   // Result side back-pressure.
   initial begin : sink_pacing
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
            if ($urandom_range(0, 4) == 0) begin
               hold = idle_gap();
            end
         end
      end
   end

   // Offer one item from a falling edge and return at the falling edge after
   // it has been accepted, with tvalid still high.
   task automatic send_item(input func_type fn, input logic [7:0] data_byte,
                            input logic [6:0] slat, input logic [2:0] field);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {6'd0, field, slat, data_byte};
      req_tuser  = fn;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (fn != FUNC_NONE) begin
         items_sent++;
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(FUNC_BYTE, b, 7'($urandom), 3'($urandom));
   endtask

   task automatic send_tick();
      send_item(FUNC_TICK, 8'($urandom), 7'($urandom), 3'($urandom));
   endtask

   task automatic send_read(input logic [6:0] slat, input logic [2:0] field);
      send_item(FUNC_READ, 8'($urandom), slat, field);
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (responses_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      drain_responses();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      timeout_now = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // A complete frame with random content, reads and the odd tick mixed in.
   task automatic send_job_frame();
      logic [7:0] pl [0:PAYLOAD_BYTES-1];
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         pl[0] = 8'($urandom_range(1, SLAT_COUNT));
      end else if (roll < 80) begin
         pl[0] = 8'd0;
      end else if (roll < 90) begin
         pl[0] = 8'($urandom_range(SLAT_COUNT + 1, 255));
      end else begin
         pl[0] = roll[0] ? 8'd1 : 8'(SLAT_COUNT);
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         pl[1] = 8'($urandom_range(0, 1));
      end else if (roll < 85) begin
         pl[1] = 8'($urandom_range(2, 8));
      end else if (roll < 95) begin
         pl[1] = 8'($urandom_range(60, 80));
      end else begin
         pl[1] = 8'($urandom_range(200, 255));
      end
      for (int i = 2; i < PAYLOAD_BYTES; i++) begin
         pl[i] = 8'($urandom);
      end
      // Clear requests and zero ramps come up often.
      if ($urandom_range(0, 3) == 0) begin
         pl[2] = 8'd0;
      end
      if ($urandom_range(0, 4) == 0) begin
         pl[6] = 8'd0;
         pl[7] = 8'd0;
      end
      if ($urandom_range(0, 4) == 0) begin
         pl[10] = 8'd0;
         pl[11] = 8'd0;
      end
      send_byte(HEADER_BYTE);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_read(random_slat(), 3'($urandom));
         end
         if (timeout_now > 16'd4 && $urandom_range(0, 39) == 0) begin
            send_tick();
         end
         send_byte(pl[i]);
      end
   endtask

   // A header and part of a payload, then timed out, or padded with junk
   // where the timeout is too long to reach.
   task automatic send_broken_frame();
      int kept;
      kept = $urandom_range(0, PAYLOAD_BYTES - 1);
      send_byte(HEADER_BYTE);
      repeat (kept) send_byte(8'($urandom));
      if (timeout_now <= 16'd64) begin
         repeat ((timeout_now == 16'd0) ? 1 : int'(timeout_now)) send_tick();
      end else begin
         repeat (PAYLOAD_BYTES - kept) send_byte(8'($urandom));
      end
   endtask

   initial begin : stimulus
      int phase_end;
      int pick;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, out of range read, unused code, idle tick.
      send_read(7'd0, 3'd0);
      send_read(7'd127, 3'd7);
      send_item(FUNC_NONE, 8'hFF, 7'h7F, 3'h7);
      send_tick();

      // Directed: a frame at the last slat running over the end, a header
      // value as payload, a full ramp and a zero second ramp.
      send_byte(HEADER_BYTE);
      send_byte(8'(SLAT_COUNT));
      send_byte(8'd2);
      send_byte(HEADER_BYTE);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h0F);
      send_byte(8'h00);
      send_byte(8'h00);
      send_read(7'(SLAT_COUNT), 3'd2);
      send_read(7'(SLAT_COUNT), 3'd3);
      send_read(7'd1, 3'd5);
      send_read(7'd1, 3'd6);

      // Random phases, one per timeout setting.
      foreach (phase_timeouts[p]) begin
         write_timeout(phase_timeouts[p]);
         quiet = (p == 2);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 19) == 0) begin
               quiet = !quiet;
            end
            if ($urandom_range(0, 49) == 0) begin
               drain_responses();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_job_frame();
            end else if (pick < 55) begin
               send_broken_frame();
            end else if (pick < 75) begin
               send_read(random_slat(), 3'($urandom));
            end else if (pick < 85) begin
               send_tick();
            end else if (pick < 90) begin
               send_item(FUNC_NONE, 8'($urandom), 7'($urandom), 3'($urandom));
            end else begin
               send_byte(($urandom_range(0, 4) == 0) ? HEADER_BYTE : 8'($urandom));
            end
         end
      end

      drain_responses();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
